FILE: design/hmc3_pkg.sv
// Package: shared widths, register indexes, reset values and filter types for the 3x3 filter.
`timescale 1ns / 1ps
`default_nettype none

package hmc3_pkg;

	// Payload and arithmetic widths
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int NTAPS      = 9;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = PROD_W + 3;
	localparam int SCALE_W    = ACC_W + GAIN_W + 1;
	localparam int FRAC_SHIFT = 27;
	localparam int TAP_IDX_W  = $clog2(NTAPS);

	// Configuration register widths
	localparam int FW_W       = 11;
	localparam int FH_W       = 16;
	localparam int ROW_CFG_W  = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam int DEFAULT_MAX_WIDTH = 1024;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN    = 3'd5;

	// Register reset values
	localparam logic [FW_W-1:0]      RST_FRAME_WIDTH  = 11'd1024;
	localparam logic [FH_W-1:0]      RST_FRAME_HEIGHT = 16'd1024;
	localparam logic [ROW_CFG_W-1:0] RST_COEF_TOP     = 48'h0000_0800_0000;
	localparam logic [ROW_CFG_W-1:0] RST_COEF_MID     = 48'h0800_E000_0800;
	localparam logic [ROW_CFG_W-1:0] RST_COEF_BOT     = 48'h0000_0800_0000;
	localparam logic [GAIN_W-1:0]    RST_DAMP_GAIN    = 16'd29491;

	typedef logic [NTAPS-1:0][SAMPLE_W-1:0] tap_vec_t;

	// Filter unit request and response
	typedef struct packed {
		logic     start;
		tap_vec_t pix;
		tap_vec_t coef;
	} filt_req_t;

	typedef struct packed {
		logic                done;
		logic [SAMPLE_W-1:0] value;
	} filt_rsp_t;

endpackage

`default_nettype wire

FILE: design/hmc3_in_if.sv
// Interface: input sample channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface hmc3_in_if import hmc3_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       drain;

	modport source (output valid, output sample, output drain, input ready);
	modport sink (input valid, input sample, input drain, output ready);
endinterface

`default_nettype wire

FILE: design/hmc3_out_if.sv
// Interface: filtered result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface hmc3_out_if import hmc3_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] filtered;
	logic                       frame_last;
	logic                       run_last;

	modport source (output valid, output filtered, output frame_last, output run_last,
		input ready);
	modport sink (input valid, input filtered, input frame_last, input run_last,
		output ready);
endinterface

`default_nettype wire

FILE: design/hmc3_line_mem.sv
// Line store: single-port-write, single-read synchronous memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hmc3_line_mem import hmc3_pkg::*; #(
	parameter int DEPTH = DEFAULT_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [AW-1:0]       waddr,
	input  wire logic [SAMPLE_W-1:0] wdata,
	input  wire logic                re,
	input  wire logic [AW-1:0]       raddr,
	output logic      [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered on the clock after the address
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/hmc3_filter.sv
// Filter unit: serial nine-tap multiply-accumulate, gain multiply, floor and saturate.
`timescale 1ns / 1ps
`default_nettype none

module hmc3_filter import hmc3_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire filt_req_t         req,
	input  wire logic [GAIN_W-1:0] gain,
	output filt_rsp_t              rsp
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_MAC,
		F_ACC,
		F_GAIN,
		F_SAT
	} fstate_t;

	localparam logic signed [SCALE_W-1:0] SAT_MAX = SCALE_W'(32767);
	localparam logic signed [SCALE_W-1:0] SAT_MIN = -SCALE_W'(32768);

	fstate_t                    state_q;
	logic [TAP_IDX_W-1:0]       tap_q;
	logic                       prod_v_s1;
	logic                       done_q;
	logic [SAMPLE_W-1:0]        value_q;

	tap_vec_t                   pix_q;
	tap_vec_t                   coef_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SCALE_W-1:0]  scaled_s2;
	logic signed [SCALE_W-1:0]  shifted;
	logic [SAMPLE_W-1:0]        sat_val;

	// floor to Q8.8 and clamp to 16 bits
	always_comb begin
		shifted = scaled_s2 >>> FRAC_SHIFT;
		if (shifted > SAT_MAX) begin
			sat_val = SAT_MAX[SAMPLE_W-1:0];
		end else if (shifted < SAT_MIN) begin
			sat_val = SAT_MIN[SAMPLE_W-1:0];
		end else begin
			sat_val = shifted[SAMPLE_W-1:0];
		end
	end

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			tap_q     <= '0;
			prod_v_s1 <= 1'b0;
			done_q    <= 1'b0;
			value_q   <= '0;
		end else begin
			done_q    <= 1'b0;
			prod_v_s1 <= 1'b0;
			case (state_q)
				F_IDLE: begin
					if (req.start) begin
						tap_q   <= '0;
						state_q <= F_MAC;
					end
				end
				F_MAC: begin
					prod_v_s1 <= 1'b1;
					tap_q     <= tap_q + 1'b1;
					if (tap_q == TAP_IDX_W'(NTAPS - 1)) begin
						state_q <= F_ACC;
					end
				end
				F_ACC: begin
					state_q <= F_GAIN;
				end
				F_GAIN: begin
					state_q <= F_SAT;
				end
				F_SAT: begin
					done_q  <= 1'b1;
					value_q <= sat_val;
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// datapath: operand latch, product, accumulator, gain product
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && req.start) begin
			pix_q  <= req.pix;
			coef_q <= req.coef;
			acc_q  <= '0;
		end else if (prod_v_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		prod_s1   <= $signed(pix_q[tap_q]) * $signed(coef_q[tap_q]);
		scaled_s2 <= acc_q * $signed({1'b0, gain});
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

endmodule

`default_nettype wire

FILE: design/heightmap_conv3x3_damped_unit.sv
// A border result passes the read and emit states after its sample is accepted, an interior
// result also the serial nine-tap multiply-accumulate; the second result of a row end follows
// once the first is taken. A new sample or drain item is accepted only in idle, once the
// previous one is finished, and output stalls hold the flow.
// Reset clears counters, window, handshake state and loads the register defaults; the line
// stores are not cleared, and their data is used only after being written within a frame.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_conv3x3_damped_unit import hmc3_pkg::*; #(
	parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	hmc3_in_if.sink                    samples,
	hmc3_out_if.source                 results,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CALC,
		S_EMIT1,
		S_EMIT2,
		S_DRAIN
	} state_t;

	// configuration registers
	logic [FW_W-1:0]      frame_width_q;
	logic [FH_W-1:0]      frame_height_q;
	logic [ROW_CFG_W-1:0] coef_row_q [3];
	logic [GAIN_W-1:0]    damp_gain_q;
	logic                 cfg_restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			coef_row_q[0]  <= RST_COEF_TOP;
			coef_row_q[1]  <= RST_COEF_MID;
			coef_row_q[2]  <= RST_COEF_BOT;
			damp_gain_q    <= RST_DAMP_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				REG_COEF_TOP:     coef_row_q[0]  <= cfg_data[ROW_CFG_W-1:0];
				REG_COEF_MID:     coef_row_q[1]  <= cfg_data[ROW_CFG_W-1:0];
				REG_COEF_BOT:     coef_row_q[2]  <= cfg_data[ROW_CFG_W-1:0];
				REG_DAMP_GAIN:    damp_gain_q    <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_restart = cfg_we &&
		(cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	// effective frame geometry
	logic [CW-1:0]   eff_w;
	logic [FH_W-1:0] eff_h;

	always_comb begin
		if (32'(frame_width_q) < 32'd3) begin
			eff_w = CW'(3);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(frame_width_q);
		end
		eff_h = (frame_height_q < FH_W'(3)) ? FH_W'(3) : frame_height_q;
	end

	// control and window state
	state_t              state_q;
	logic [AW-1:0]       col_q;
	logic [FH_W-1:0]     row_q;
	logic [AW-1:0]       drain_cnt_q;
	logic                pending_q;
	logic [SAMPLE_W-1:0] win_q [6];

	logic [AW-1:0]       waddr_s1;
	logic [SAMPLE_W-1:0] bot_s1;
	logic                emit_s1;
	logic                interior_s1;
	logic                two_s1;
	logic                dlast_q;
	logic [SAMPLE_W-1:0] res_val_q;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_filtered_q;
	logic                out_frame_last_q;
	logic                out_run_last_q;

	logic                accept;
	logic                sample_acc;
	logic                slot_free;
	logic [AW-1:0]       c_eff;
	logic [FH_W-1:0]     r_eff;
	logic                col_wrap;
	logic                row_wrap;
	logic                drain_done;

	logic [SAMPLE_W-1:0] upper_rdata;
	logic [SAMPLE_W-1:0] lower_rdata;
	logic                mem_we;

	filt_req_t           filt_req;
	filt_rsp_t           filt_rsp;

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign sample_acc    = accept && !samples.drain;
	assign slot_free     = !out_valid_q || results.ready;

	// a sample after a finished frame starts the next one
	assign c_eff      = pending_q ? '0 : col_q;
	assign r_eff      = pending_q ? '0 : row_q;
	assign col_wrap   = (CW'(c_eff) + 1'b1) == eff_w;
	assign row_wrap   = (17'(r_eff) + 1'b1) == 17'(eff_h);
	assign drain_done = (CW'(drain_cnt_q) + 1'b1) == eff_w;
	assign mem_we     = (state_q == S_RD);

	// line stores
	hmc3_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_upper (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr_s1),
		.wdata (lower_rdata),
		.re    (sample_acc),
		.raddr (c_eff),
		.rdata (upper_rdata)
	);

	hmc3_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_lower (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr_s1),
		.wdata (bot_s1),
		.re    (sample_acc),
		.raddr (c_eff),
		.rdata (lower_rdata)
	);

	// 3x3 window and kernel, tap index = row * 3 + column
	always_comb begin
		filt_req.start  = (state_q == S_RD) && interior_s1;
		filt_req.pix[0] = win_q[3];
		filt_req.pix[1] = win_q[0];
		filt_req.pix[2] = upper_rdata;
		filt_req.pix[3] = win_q[4];
		filt_req.pix[4] = win_q[1];
		filt_req.pix[5] = lower_rdata;
		filt_req.pix[6] = win_q[5];
		filt_req.pix[7] = win_q[2];
		filt_req.pix[8] = bot_s1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				filt_req.coef[r * 3 + c] = coef_row_q[r][COEF_W * c +: COEF_W];
			end
		end
	end

	hmc3_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (filt_req),
		.gain   (damp_gain_q),
		.rsp    (filt_rsp)
	);

	// sequencer, counters, window and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			col_q            <= '0;
			row_q            <= '0;
			drain_cnt_q      <= '0;
			pending_q        <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
			waddr_s1         <= '0;
			bot_s1           <= '0;
			emit_s1          <= 1'b0;
			interior_s1      <= 1'b0;
			two_s1           <= 1'b0;
			dlast_q          <= 1'b0;
			res_val_q        <= '0;
			out_valid_q      <= 1'b0;
			out_filtered_q   <= '0;
			out_frame_last_q <= 1'b0;
			out_run_last_q   <= 1'b0;
		end else begin
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && samples.drain) begin
						if (pending_q) begin
							dlast_q <= drain_done;
							if (drain_done) begin
								drain_cnt_q <= '0;
								pending_q   <= 1'b0;
							end else begin
								drain_cnt_q <= drain_cnt_q + 1'b1;
							end
							state_q <= S_DRAIN;
						end
					end else if (accept) begin
						waddr_s1    <= c_eff;
						bot_s1      <= samples.sample;
						emit_s1     <= (r_eff != '0) && (c_eff != '0);
						interior_s1 <= (r_eff > FH_W'(1)) && (c_eff > AW'(1));
						two_s1      <= col_wrap;
						drain_cnt_q <= '0;
						if (col_wrap) begin
							col_q <= '0;
							if (row_wrap) begin
								row_q     <= '0;
								pending_q <= 1'b1;
							end else begin
								row_q     <= r_eff + 1'b1;
								pending_q <= 1'b0;
							end
						end else begin
							col_q     <= c_eff + 1'b1;
							row_q     <= r_eff;
							pending_q <= 1'b0;
						end
						state_q <= S_RD;
					end
				end
				S_RD: begin
					win_q[3] <= win_q[0];
					win_q[4] <= win_q[1];
					win_q[5] <= win_q[2];
					win_q[0] <= upper_rdata;
					win_q[1] <= lower_rdata;
					win_q[2] <= bot_s1;
					res_val_q <= '0;
					if (interior_s1) begin
						state_q <= S_CALC;
					end else if (emit_s1) begin
						state_q <= S_EMIT1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_CALC: begin
					if (filt_rsp.done) begin
						res_val_q <= filt_rsp.value;
						state_q   <= S_EMIT1;
					end
				end
				S_EMIT1: begin
					if (slot_free) begin
						out_valid_q      <= 1'b1;
						out_filtered_q   <= res_val_q;
						out_frame_last_q <= 1'b0;
						out_run_last_q   <= !two_s1;
						state_q          <= two_s1 ? S_EMIT2 : S_IDLE;
					end
				end
				S_EMIT2: begin
					if (slot_free) begin
						out_valid_q      <= 1'b1;
						out_filtered_q   <= '0;
						out_frame_last_q <= 1'b0;
						out_run_last_q   <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				S_DRAIN: begin
					if (slot_free) begin
						out_valid_q      <= 1'b1;
						out_filtered_q   <= '0;
						out_frame_last_q <= dlast_q;
						out_run_last_q   <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// geometry write restarts the frame
			if (cfg_restart) begin
				col_q       <= '0;
				row_q       <= '0;
				drain_cnt_q <= '0;
				pending_q   <= 1'b0;
			end
		end
	end

	assign results.valid      = out_valid_q;
	assign results.filtered   = out_filtered_q;
	assign results.frame_last = out_frame_last_q;
	assign results.run_last   = out_run_last_q;

`ifndef NO_ASSERTIONS
	// filter results only arrive while the sequencer waits for them
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		filt_rsp.done |-> state_q == S_CALC)
		else $error("filter result outside of calc state");

	// column counter stays inside the row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(eff_w))
		else $error("column counter beyond frame width");

	// a finished frame leaves the position counters at the origin
	a_pending_origin: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (col_q == '0 && row_q == '0))
		else $error("drain pending with nonzero position");

	// drain progress only exists while the last row is pending
	a_drain_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_cnt_q != '0) |-> pending_q)
		else $error("drain count without pending last row");

	// memory data is consumed in the cycle after a sample transaction
	a_rd_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> $past(samples.valid && samples.ready && !samples.drain))
		else $error("line-store read state without a sample transaction");
`endif

endmodule

`default_nettype wire
